>>> hdl/two_point_rotation_angle_macros.svh
// Assertion macros for the two-point rotation angle block.
`ifndef TWO_POINT_ROTATION_ANGLE_MACROS_SVH
`define TWO_POINT_ROTATION_ANGLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define TPRA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("two_point_rotation_angle: check failed");
// Checked at every edge, reset included.
`define TPRA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("two_point_rotation_angle: reset check failed");
`else
`define TPRA_ASSERT(lbl, clk, rst, prop)
`define TPRA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hdl/tpra_pkg.sv
// Shared types, constants and the arctangent table of the rotation angle block.
package tpra_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_ITERS = 24;
  localparam int GUARD_BITS   = 59 - COORD_WIDTH;
  localparam int DIFF_W       = COORD_WIDTH + 1;
  localparam int VEC_W        = COORD_WIDTH + 2;
  localparam int CORD_W       = VEC_W + GUARD_BITS + 3;
  localparam int ZW           = 34;
  localparam int ANGLE_W      = 25;
  localparam int LIMIT_W      = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic signed [ZW-1:0] ANG_HALF = ZW'(64'sd180 * 64'sd16777216);
  localparam logic signed [ZW-1:0] ANG_FULL = ZW'(64'sd360 * 64'sd16777216);

  // Output angle limits, plus and minus 180 degrees in Q8.16.
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 25'sd11796480;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -25'sd11796480;

  localparam logic [CFG_IDX_W-1:0] REG_SWAP_ROLES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_ZERO_LIMIT = 2'd1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_REF_SAME   = 3'd1,
    ST_VERT_NO_MY = 3'd2,
    ST_HORZ_NO_MX = 3'd3,
    ST_MEAS_ZERO  = 3'd4
  } status_t;

  // One classified item: vector A, and vector B for the general case.
  typedef struct packed {
    logic                    general;
    status_t                 st;
    logic signed [VEC_W-1:0] ax;
    logic signed [VEC_W-1:0] ay;
    logic signed [VEC_W-1:0] bx;
    logic signed [VEC_W-1:0] by;
  } job_t;

  // atan(2^-i) in degrees scaled by 2^24.
  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      5'd24: v = 34'sd57;
      5'd25: v = 34'sd29;
      5'd26: v = 34'sd14;
      5'd27: v = 34'sd7;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/tpra_front.sv
// Front end: takes point sets, forms the difference vectors and classifies them.
module tpra_front (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  first_ref_x,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  first_ref_y,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  first_meas_x,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  first_meas_y,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  second_ref_x,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  second_ref_y,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  second_meas_x,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  second_meas_y,
  input  logic                                     swap_roles,
  input  logic [tpra_pkg::LIMIT_W-1:0]             near_zero_limit,
  output logic                                     job_valid,
  input  logic                                     job_full,
  output tpra_pkg::job_t                           job
);

  localparam int DW = tpra_pkg::DIFF_W;
  localparam int VW = tpra_pkg::VEC_W;

  logic                 fv;
  logic signed [DW-1:0] drx, dry, dmx, dmy;
  logic signed [DW-1:0] rx, ry, mx, my;
  logic                 srx, sry, smx, smy;

  // A set is held here until the queue can take it.
  assign in_stall  = fv && job_full;
  assign job_valid = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (!in_stall) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      drx <= DW'(second_ref_x)  - DW'(first_ref_x);
      dry <= DW'(second_ref_y)  - DW'(first_ref_y);
      dmx <= DW'(second_meas_x) - DW'(first_meas_x);
      dmy <= DW'(second_meas_y) - DW'(first_meas_y);
    end
  end

  function automatic logic is_small(input logic signed [DW-1:0] d,
                                    input logic [tpra_pkg::LIMIT_W-1:0] lim);
    logic [DW-1:0] a;
    a = d[DW-1] ? DW'(-d) : DW'(d);
    return (d == '0) || (a < DW'(lim));
  endfunction

  // Role swap and near-zero tests.
  always_comb begin
    rx = swap_roles ? dmx : drx;
    ry = swap_roles ? dmy : dry;
    mx = swap_roles ? drx : dmx;
    my = swap_roles ? dry : dmy;
    srx = is_small(rx, near_zero_limit);
    sry = is_small(ry, near_zero_limit);
    smx = is_small(mx, near_zero_limit);
    smy = is_small(my, near_zero_limit);
  end

  // Pick the case and the vectors the back end rotates.
  always_comb begin
    job.general = 1'b0;
    job.st      = tpra_pkg::ST_OK;
    job.ax      = VW'(mx);
    job.ay      = VW'(my);
    job.bx      = VW'(rx);
    job.by      = VW'(ry);
    if (srx && sry) begin
      job.st = tpra_pkg::ST_REF_SAME;
    end else if (srx) begin
      // Vertical reference: atan(-mx / my).
      if (smy) begin
        job.st = tpra_pkg::ST_VERT_NO_MY;
      end else if (my[DW-1]) begin
        job.ax = -VW'(my);
        job.ay = VW'(mx);
      end else begin
        job.ax = VW'(my);
        job.ay = -VW'(mx);
      end
    end else if (sry) begin
      // Horizontal reference: atan(my / mx).
      if (smx) begin
        job.st = tpra_pkg::ST_HORZ_NO_MX;
      end else if (mx[DW-1]) begin
        job.ax = -VW'(mx);
        job.ay = -VW'(my);
      end
    end else if (smx && smy) begin
      job.st = tpra_pkg::ST_MEAS_ZERO;
    end else begin
      job.general = 1'b1;
    end
  end

endmodule

>>> hdl/tpra_fifo.sv
// Two-entry queue of classified items between the front and back ends.
module tpra_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  tpra_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output tpra_pkg::job_t rd_data
);

  tpra_pkg::job_t mem [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;
  logic           do_wr, do_rd;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

>>> hdl/tpra_back.sv
// Back end: two pipelined vectoring CORDICs and the angle combine stage.
module tpra_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    job_valid,
  input  tpra_pkg::job_t                          job,
  output logic                                    job_pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [tpra_pkg::ANGLE_W-1:0]     angle_deg,
  output logic [2:0]                              status
);

  localparam int N  = tpra_pkg::CORDIC_ITERS;
  localparam int CW = tpra_pkg::CORD_W;
  localparam int ZW = tpra_pkg::ZW;
  localparam int GB = tpra_pkg::GUARD_BITS;

  logic                 adv;
  logic                 v   [N+1];
  logic                 gen [N+1];
  tpra_pkg::status_t    st  [N+1];
  logic signed [CW-1:0] ax  [N+1];
  logic signed [CW-1:0] ay  [N+1];
  logic signed [ZW-1:0] az  [N+1];
  logic signed [CW-1:0] bx  [N+1];
  logic signed [CW-1:0] by  [N+1];
  logic signed [ZW-1:0] bz  [N+1];
  logic signed [ZW-1:0] d, dw, dabs, rnd;

  // The whole pipeline moves together unless the result is held.
  assign adv     = !(out_valid && out_stall);
  assign job_pop = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) v[k] <= 1'b0;
    end else if (adv) begin
      v[0] <= job_valid;
      for (int k = 1; k <= N; k++) v[k] <= v[k-1];
    end
  end

  // Left half-plane fold and guard scaling.
  always_ff @(posedge clk) begin
    if (adv) begin
      gen[0] <= job.general;
      st[0]  <= job.st;
      if (job.ax[tpra_pkg::VEC_W-1]) begin
        ax[0] <= CW'(-job.ax) <<< GB;
        ay[0] <= CW'(-job.ay) <<< GB;
        az[0] <= tpra_pkg::ANG_HALF;
      end else begin
        ax[0] <= CW'(job.ax) <<< GB;
        ay[0] <= CW'(job.ay) <<< GB;
        az[0] <= '0;
      end
      if (job.bx[tpra_pkg::VEC_W-1]) begin
        bx[0] <= CW'(-job.bx) <<< GB;
        by[0] <= CW'(-job.by) <<< GB;
        bz[0] <= tpra_pkg::ANG_HALF;
      end else begin
        bx[0] <= CW'(job.bx) <<< GB;
        by[0] <= CW'(job.by) <<< GB;
        bz[0] <= '0;
      end
    end
  end

  // One micro-rotation per stage for each vector.
  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (adv) begin
        gen[i+1] <= gen[i];
        st[i+1]  <= st[i];
        if (!ay[i][CW-1]) begin
          ax[i+1] <= ax[i] + (ay[i] >>> i);
          ay[i+1] <= ay[i] - (ax[i] >>> i);
          az[i+1] <= az[i] + tpra_pkg::atan_val(5'(i));
        end else begin
          ax[i+1] <= ax[i] - (ay[i] >>> i);
          ay[i+1] <= ay[i] + (ax[i] >>> i);
          az[i+1] <= az[i] - tpra_pkg::atan_val(5'(i));
        end
        if (!by[i][CW-1]) begin
          bx[i+1] <= bx[i] + (by[i] >>> i);
          by[i+1] <= by[i] - (bx[i] >>> i);
          bz[i+1] <= bz[i] + tpra_pkg::atan_val(5'(i));
        end else begin
          bx[i+1] <= bx[i] - (by[i] >>> i);
          by[i+1] <= by[i] + (bx[i] >>> i);
          bz[i+1] <= bz[i] - tpra_pkg::atan_val(5'(i));
        end
      end
    end
  end

  // Difference wrapped to (-180, 180], magnitude, or angle A; rounding.
  always_comb begin
    d = az[N] - bz[N];
    if (d > tpra_pkg::ANG_HALF) begin
      dw = d - tpra_pkg::ANG_FULL;
    end else if (d <= -tpra_pkg::ANG_HALF) begin
      dw = d + tpra_pkg::ANG_FULL;
    end else begin
      dw = d;
    end
    dabs = dw[ZW-1] ? -dw : dw;
    rnd  = ((gen[N] ? dabs : az[N]) + ZW'(128)) >>> 8;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status    <= st[N];
      angle_deg <= (st[N] == tpra_pkg::ST_OK) ? rnd[tpra_pkg::ANGLE_W-1:0] : '0;
    end
  end

endmodule

>>> hdl/two_point_rotation_angle.sv
// Top level of the two-point rotation angle block.
// Input channel: in_valid/in_stall carry a set of two reference points and their
// two measured images, each coordinate signed Q15.16. Output channel:
// out_valid/out_stall carry angle_deg (signed Q8.16 degrees) and status; the
// angle is zero whenever status reports a failure.
// A transfer happens on a rising edge with valid high and stall low.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 swap_roles,
// 1 near_zero_limit); users write only while the block is idle (not enforced).
// Path: input register, queue, fold stage, 24 CORDIC stages and the result
// register. One set is accepted per cycle while the receiver does not stall;
// the rate is set by the fully pipelined CORDIC stages, one micro-rotation each.
// When the receiver stalls, the back pipeline holds and the two-entry queue
// fills; in_stall rises once the queue is full and the input register holds a
// set, which in steady flow is the cycle after the stall begins.
// Reset (rst, synchronous) empties the pipeline and queue and sets
// swap_roles to 0 and near_zero_limit to 1.
`include "two_point_rotation_angle_macros.svh"
module two_point_rotation_angle (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  first_ref_x,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  first_ref_y,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  first_meas_x,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  first_meas_y,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  second_ref_x,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  second_ref_y,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  second_meas_x,
  input  logic signed [tpra_pkg::COORD_WIDTH-1:0]  second_meas_y,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [tpra_pkg::ANGLE_W-1:0]      angle_deg,
  output logic [2:0]                               status,
  input  logic                                     cfg_we,
  input  logic [tpra_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [tpra_pkg::LIMIT_W-1:0]             cfg_data
);

  logic                          swap_roles;
  logic [tpra_pkg::LIMIT_W-1:0]  near_zero_limit;
  logic                          f_valid, q_full, q_valid, q_pop;
  tpra_pkg::job_t                f_job, q_job;
  logic                          item_failed, angle_in_range;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_roles      <= 1'b0;
      near_zero_limit <= tpra_pkg::LIMIT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        tpra_pkg::REG_SWAP_ROLES:      swap_roles      <= cfg_data[0];
        tpra_pkg::REG_NEAR_ZERO_LIMIT: near_zero_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  tpra_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .first_ref_x, .first_ref_y, .first_meas_x, .first_meas_y,
    .second_ref_x, .second_ref_y, .second_meas_x, .second_meas_y,
    .swap_roles, .near_zero_limit,
    .job_valid (f_valid),
    .job_full  (q_full),
    .job       (f_job)
  );

  tpra_fifo u_fifo (
    .clk, .rst,
    .wr_en    (f_valid),
    .wr_data  (f_job),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_job)
  );

  tpra_back u_back (
    .clk, .rst,
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .out_valid, .out_stall, .angle_deg, .status
  );

  // Terms used by the checks below.
  assign item_failed    = out_valid && (status != tpra_pkg::ST_OK);
  assign angle_in_range = (angle_deg <= tpra_pkg::ANGLE_MAX) &&
                          (angle_deg >= tpra_pkg::ANGLE_MIN);

  // A failed item always carries a zero angle.
  `TPRA_ASSERT(a_fail_zero, clk, rst, item_failed |-> (angle_deg == '0))
  // The angle stays within half a turn.
  `TPRA_ASSERT(a_range, clk, rst, out_valid |-> angle_in_range)
  // Reset leaves no result pending.
  `TPRA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

>>> tb/sv/two_point_rotation_angle_tb.sv
// Testbench for the two-point rotation angle block: random and directed point sets.
module two_point_rotation_angle_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT = 28;

  // One expected result.
  typedef struct {
    logic signed [tpra_pkg::ANGLE_W-1:0] angle;
    tpra_pkg::status_t                   st;
  } angle_res_t;

  // Angle predictor with its own copy of the two registers.
  class angle_scoreboard;
    bit           swap;
    int unsigned  zlim;
    angle_res_t   pending[$];
    int           n_err;

    function void set_reg(logic [tpra_pkg::CFG_IDX_W-1:0] idx,
                          logic [tpra_pkg::LIMIT_W-1:0] val);
      if (idx == tpra_pkg::REG_SWAP_ROLES) swap = val[0];
      else if (idx == tpra_pkg::REG_NEAR_ZERO_LIMIT) zlim = val;
    endfunction

    function bit near_zero(longint d);
      longint a;
      a = (d < 0) ? -d : d;
      return (d == 0) || (a < longint'(zlim));
    endfunction

    function longint tab(int i);
      longint t[32] = '{754974720, 445687602, 235489088, 119537938, 60000934,
        30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
        29, 14, 7, 4, 2, 1, 0};
      return t[i];
    endfunction

    // Vectoring CORDIC: angle of (x, y) in degrees scaled by 2^24.
    function longint cordic_angle(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 180 * 64'sd16777216;
      end
      x = x <<< tpra_pkg::GUARD_BITS;
      y = y <<< tpra_pkg::GUARD_BITS;
      for (int i = 0; i < tpra_pkg::CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += tab(i);
        end else begin
          x -= dx; y += dy; z -= tab(i);
        end
      end
      return z;
    endfunction

    function longint ratio(longint num, longint den);
      if (den < 0) return cordic_angle(-den, -num);
      return cordic_angle(den, num);
    endfunction

    function void note_input(logic signed [31:0] p[8]);
      longint rx, ry, mx, my, t, ang, d, half;
      tpra_pkg::status_t st;
      angle_res_t r;
      half = 180 * 64'sd16777216;
      rx = longint'(p[4]) - longint'(p[0]);
      ry = longint'(p[5]) - longint'(p[1]);
      mx = longint'(p[6]) - longint'(p[2]);
      my = longint'(p[7]) - longint'(p[3]);
      ang = 0;
      st = tpra_pkg::ST_OK;
      if (swap) begin
        t = rx; rx = mx; mx = t;
        t = ry; ry = my; my = t;
      end
      if (near_zero(rx) && near_zero(ry)) st = tpra_pkg::ST_REF_SAME;
      else if (near_zero(rx)) begin
        if (near_zero(my)) st = tpra_pkg::ST_VERT_NO_MY;
        else ang = ratio(-mx, my);
      end else if (near_zero(ry)) begin
        if (near_zero(mx)) st = tpra_pkg::ST_HORZ_NO_MX;
        else ang = ratio(my, mx);
      end else if (near_zero(mx) && near_zero(my)) st = tpra_pkg::ST_MEAS_ZERO;
      else begin
        d = cordic_angle(mx, my) - cordic_angle(rx, ry);
        while (d > half) d -= 2 * half;
        while (d <= -half) d += 2 * half;
        ang = (d < 0) ? -d : d;
      end
      ang = (st != tpra_pkg::ST_OK) ? 0 : ((ang + 128) >>> 8);
      r.angle = ang[tpra_pkg::ANGLE_W-1:0];
      r.st = st;
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [tpra_pkg::ANGLE_W-1:0] a, logic [2:0] s);
      angle_res_t e;
      if (pending.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result angle %0d status %0d", a, s);
        return;
      end
      e = pending.pop_front();
      if (a !== e.angle || s !== e.st) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch: angle %0d/%0d status %0d/%0d (exp/act)",
                   e.angle, a, e.st, s);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [31:0] pt[8] = '{default: '0};
  logic signed [tpra_pkg::ANGLE_W-1:0] angle_deg;
  logic [2:0] status;
  logic cfg_we = 0;
  logic [tpra_pkg::CFG_IDX_W-1:0] cfg_index = tpra_pkg::REG_SWAP_ROLES;
  logic [tpra_pkg::LIMIT_W-1:0] cfg_data = '0;
  int send_idle = 0, recv_idle = 0;
  angle_scoreboard sb;

  always #2 clk = ~clk;

  two_point_rotation_angle dut (
    .clk, .rst, .in_valid, .in_stall,
    .first_ref_x(pt[0]), .first_ref_y(pt[1]), .first_meas_x(pt[2]),
    .first_meas_y(pt[3]), .second_ref_x(pt[4]), .second_ref_y(pt[5]),
    .second_meas_x(pt[6]), .second_meas_y(pt[7]),
    .out_valid, .out_stall, .angle_deg, .status, .cfg_we, .cfg_index, .cfg_data
  );

  // Receiver stall and result checking.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(angle_deg, status);
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Sends one point set, with random idle cycles before it.
  task automatic send_set(logic signed [31:0] p[8]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 8; i++) pt[i] <= p[i];
    do @(posedge clk); while (in_stall);
    sb.note_input(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [tpra_pkg::CFG_IDX_W-1:0] idx,
                           logic [tpra_pkg::LIMIT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Builds a set from a reference vector and a measured vector at random bases.
  task automatic send_vecs(longint rx, longint ry, longint mx, longint my);
    logic signed [31:0] p[8];
    for (int i = 0; i < 4; i++) p[i] = $urandom;
    p[4] = 32'(p[0] + rx); p[5] = 32'(p[1] + ry);
    p[6] = 32'(p[2] + mx); p[7] = 32'(p[3] + my);
    send_set(p);
  endtask

  function automatic longint rnd_comp();
    case ($urandom_range(5))
      0: return 0;
      1: return longint'($urandom_range(4)) - 2;
      2: return longint'($urandom_range(200000)) - 100000;
      default: return longint'($signed($urandom));
    endcase
  endfunction

  task automatic random_phase(int n);
    logic signed [31:0] p[8];
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        for (int i = 0; i < 8; i++) p[i] = $urandom;
        send_set(p);
      end else send_vecs(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
    end
  endtask

  initial begin
    logic signed [31:0] p[8];
    sb = new();
    sb.swap = 0; sb.zlim = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: special cases and extremes.
    send_vecs(0, 0, 5, 5);
    send_vecs(0, 7, 3, 4);
    send_vecs(0, 7, 3, 0);
    send_vecs(9, 0, 3, 4);
    send_vecs(9, 0, 0, 4);
    send_vecs(9, 9, 0, 0);
    send_vecs(1, 1, -1, -1);
    send_vecs(-5, 3, 5, -3);
    send_vecs(3, -4, -7, -2);
    for (int i = 0; i < 8; i++) p[i] = (i < 4) ? 32'sh80000000 : 32'sh7fffffff;
    send_set(p);
    for (int i = 0; i < 8; i++) p[i] = (i < 4) ? 32'sh7fffffff : 32'sh80000000;
    send_set(p);
    for (int i = 0; i < 8; i++) p[i] = (i[0]) ? 32'sh80000000 : 32'sh7fffffff;
    send_set(p);
    for (int i = 0; i < 8; i++) p[i] = '1;
    send_set(p);
    drain();

    write_reg(tpra_pkg::REG_NEAR_ZERO_LIMIT, 16'hffff);
    write_reg(tpra_pkg::REG_SWAP_ROLES, 16'd1);
    send_vecs(65534, 3, 100000, 7);
    send_vecs(3, 70000, -65535, 65536);
    send_vecs(-65535, 0, 0, 65535);
    drain();

    // Random phases with different idle patterns and settings.
    send_idle = 14; recv_idle = 51;
    write_reg(tpra_pkg::REG_NEAR_ZERO_LIMIT, 16'd0);
    write_reg(tpra_pkg::REG_SWAP_ROLES, 16'd0);
    random_phase(150);
    drain();
    send_idle = 51; recv_idle = 14;
    write_reg(tpra_pkg::REG_NEAR_ZERO_LIMIT, 16'd3);
    write_reg(tpra_pkg::REG_SWAP_ROLES, 16'd1);
    random_phase(150);
    drain();
    send_idle = 0; recv_idle = 0;
    write_reg(tpra_pkg::REG_NEAR_ZERO_LIMIT, 16'd1);
    write_reg(tpra_pkg::REG_SWAP_ROLES, 16'd0);
    random_phase(150);
    drain();

    if (sb.n_err == 0 && sb.pending.size() == 0)
      $display("two_point_rotation_angle_tb: clean");
    else
      $display("two_point_rotation_angle_tb: errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("two_point_rotation_angle_tb: errors");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hdl
hdl/tpra_pkg.sv
hdl/tpra_front.sv
hdl/tpra_fifo.sv
hdl/tpra_back.sv
hdl/two_point_rotation_angle.sv
tb/sv/two_point_rotation_angle_tb.sv
